@@ sv/gara_pkg.sv @@
// ----------------------------------------------------------------------------
// gara_pkg
// shared types and constants of the grid atlas rectangle allocator
// ----------------------------------------------------------------------------
`default_nettype none

package gara_pkg;

   localparam int GRID_SIDE_DEF    = 64;
   localparam int MAX_ATLAS_PX_DEF = 4096;
   localparam int MIN_POWER_DEF    = 16;

   localparam int CELL_PX_W   = 11;
   localparam int CELL_PX_MAX = 1024;
   localparam int CELL_PX_RST = 32;
   localparam int RECT_W      = 13;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_W = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_H = 2'd1;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam logic [1:0] ST_PLACED  = 2'd0;
   localparam logic [1:0] ST_GROWN   = 2'd1;
   localparam logic [1:0] ST_CLEARED = 2'd2;
   localparam logic [1:0] ST_NOFIT   = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE,
      S_POW,
      S_COLS_GO,
      S_COLS_WT,
      S_ROWS_GO,
      S_ROWS_WT,
      S_CLR,
      S_WDIV_GO,
      S_WDIV_WT,
      S_HDIV_GO,
      S_HDIV_WT,
      S_SC_ROW,
      S_SC_RD,
      S_SC_CK,
      S_MARK,
      S_POS,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

@@ sv/gara_divider.sv @@
// ----------------------------------------------------------------------------
// gara_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gara_divider #(
   parameter int DVW = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DVW-1:0]                dividend,
   input  wire logic [gara_pkg::CELL_PX_W-1:0] divisor,
   output logic                               busy,
   output logic [DVW-1:0]                     quotient
);
   import gara_pkg::*;

   localparam int CNW = $clog2(DVW + 1);

   logic [CELL_PX_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [DVW-1:0]       quo_ff, quo_in;
   logic [CNW-1:0]       cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [CELL_PX_W:0]   rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVW-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNW'(DVW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = CELL_PX_W'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CELL_PX_W-1:0];
            quo_in = {quo_ff[DVW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ sv/gara_grid_mem.sv @@
// ----------------------------------------------------------------------------
// gara_grid_mem
// cell span memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gara_grid_mem #(
   parameter int DEPTH = 4096,
   parameter int ADW   = 12,
   parameter int DW    = 7
) (
   input  wire logic           clock,
   input  wire logic           we,
   input  wire logic [ADW-1:0] waddr,
   input  wire logic [DW-1:0]  wdata,
   input  wire logic [ADW-1:0] raddr,
   output logic [DW-1:0]       rdata
);
   import gara_pkg::*;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/grid_atlas_rect_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// grid_atlas_rect_allocator_unit
// first-fit rectangle allocator over a grid of atlas cells
// ----------------------------------------------------------------------------
// requests come in on req_ (req_type add or clear, rectangle size in pixels),
// one result per request leaves on rsp_ through an output register, so the
// next request is taken while a result still waits for rsp_ready.
// csr_ writes the cell width (index 0) or height (index 1); csr_ready is always
// high and a write to either re-initialises the atlas.
// a request is handled by a sequencer around one shared restoring divider
// and the span memory port: an add divides the rectangle size into cells,
// reads the grid cells of each candidate position in the scan and marks
// the cells it takes; a grow adds the doubling, two more divisions and a
// rescan. a clear request, or a full atlas whose doubling would pass MAX_ATLAS_PX,
// sweeps the grid one cell a cycle, GRID_SIDE*GRID_SIDE cells (4096 by default).
// after reset and after every such csr write the atlas size is recomputed and the
// same sweep runs; req_ready stays low until it has finished.
// a stalled receiver only holds the result register; one request can be
// worked on behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_atlas_rect_allocator_unit #(
   parameter int GRID_SIDE    = gara_pkg::GRID_SIDE_DEF,
   parameter int MAX_ATLAS_PX = gara_pkg::MAX_ATLAS_PX_DEF,
   parameter int MIN_POWER    = gara_pkg::MIN_POWER_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [gara_pkg::RECT_W-1:0]   req_rect_width,
   input  wire logic [gara_pkg::RECT_W-1:0]   req_rect_height,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [gara_pkg::RECT_W-1:0] rsp_pos_x,
   output logic signed [gara_pkg::RECT_W-1:0] rsp_pos_y,
   output logic [gara_pkg::RECT_W-1:0]        rsp_atlas_width,
   output logic [gara_pkg::RECT_W-1:0]        rsp_atlas_height,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [gara_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gara_pkg::CELL_PX_W-1:0] csr_data
);
   import gara_pkg::*;

   localparam int AW    = ($clog2(MAX_ATLAS_PX) + 1 > 14) ? $clog2(MAX_ATLAS_PX) + 1 : 14;
   localparam int CNTW  = $clog2(GRID_SIDE + 1);
   localparam int XW    = $clog2(2 * GRID_SIDE + 1);
   localparam int HW    = $clog2(GRID_SIDE);
   localparam int DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADW   = $clog2(DEPTH);
   localparam int NW    = 16;
   localparam int QW    = 14;

   state_type state_ff, state_in;

   logic [CELL_PX_W-1:0] cellw_ff, cellw_in, cellh_ff, cellh_in, cwe, che;
   logic [AW-1:0]        power_ff, power_in, atw_ff, atw_in, ath_ff, ath_in;
   logic [CNTW-1:0]      cols_ff, cols_in, rows_ff, rows_in;
   logic [HW-1:0]        hc_ff, hc_in, hr_ff, hr_in;
   logic [QW-1:0]        cw_ff, cw_in, ch_ff, ch_in;
   logic [XW-1:0]        x_ff, x_in, y_ff, y_in;
   logic [CNTW-1:0]      i_ff, i_in, j_ff, j_in;
   logic                 hset_ff, hset_in, grown_ff, grown_in;
   logic                 gpath_ff, gpath_in, cresp_ff, cresp_in;
   logic [ADW-1:0]       caddr_ff, caddr_in;
   logic [RECT_W-1:0]    rw_ff, rw_in, rh_ff, rh_in;
   logic [1:0]           st_ff, st_in;
   logic [RECT_W-1:0]    px_ff, px_in, py_ff, py_in;
   logic                 ov_ff, ov_in;
   logic [1:0]           os_ff, os_in;
   logic [RECT_W-1:0]    ox_ff, ox_in, oy_ff, oy_in, ow_ff, ow_in, oh_ff, oh_in;

   logic                 div_start, div_busy;
   logic [AW-1:0]        div_dvd, div_q;
   logic [CELL_PX_W-1:0] div_dvs;

   logic                 mem_we;
   logic [ADW-1:0]       mem_waddr, mem_raddr, rc_addr;
   logic [CNTW-1:0]      mem_wdata, mem_rdata;

   logic [AW+2:0]        pw_x, ch2_x, cw4_x;
   logic [AW:0]          nw_x, nh_x;
   logic [NW-1:0]        t_x;
   logic [XW+CELL_PX_W-1:0] pxm, pym;
   logic                 req_acc, csr_acc;

   function automatic logic [CELL_PX_W-1:0] eff_px(input logic [CELL_PX_W-1:0] v);
      logic [CELL_PX_W-1:0] r;
      r = v;
      if (v == '0) r = CELL_PX_W'(1);
      else if (v > CELL_PX_W'(CELL_PX_MAX)) r = CELL_PX_W'(CELL_PX_MAX);
      return r;
   endfunction

   function automatic logic [CNTW-1:0] sat_cnt(input logic [AW-1:0] q);
      logic [CNTW-1:0] r;
      if (q > AW'(GRID_SIDE)) r = CNTW'(GRID_SIDE);
      else r = q[CNTW-1:0];
      return r;
   endfunction

   assign cwe       = eff_px(cellw_ff);
   assign che       = eff_px(cellh_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;

   assign rc_addr = ADW'((32'(y_ff) + 32'(j_ff)) * 32'(GRID_SIDE) + 32'(x_ff) + 32'(i_ff));
   assign mem_raddr = rc_addr;
   assign pxm = {{CELL_PX_W{1'b0}}, x_ff} * {{XW{1'b0}}, cwe};
   assign pym = {{CELL_PX_W{1'b0}}, y_ff} * {{XW{1'b0}}, che};

   always_comb begin
      state_in = state_ff;
      cellw_in = cellw_ff;  cellh_in = cellh_ff;
      power_in = power_ff;  atw_in = atw_ff;  ath_in = ath_ff;
      cols_in  = cols_ff;   rows_in = rows_ff;
      hc_in    = hc_ff;     hr_in = hr_ff;
      cw_in    = cw_ff;     ch_in = ch_ff;
      x_in     = x_ff;      y_in = y_ff;  i_in = i_ff;  j_in = j_ff;
      hset_in  = hset_ff;   grown_in = grown_ff;
      gpath_in = gpath_ff;  cresp_in = cresp_ff;
      caddr_in = caddr_ff;
      rw_in    = rw_ff;     rh_in = rh_ff;
      st_in    = st_ff;     px_in = px_ff;  py_in = py_ff;
      ov_in    = ov_ff;     os_in = os_ff;
      ox_in    = ox_ff;     oy_in = oy_ff;  ow_in = ow_ff;  oh_in = oh_ff;
      div_start = 1'b0;
      div_dvd   = atw_ff;
      div_dvs   = cwe;
      mem_we    = 1'b0;
      mem_waddr = rc_addr;
      mem_wdata = cw_ff[CNTW-1:0];
      pw_x  = (AW+3)'(power_ff);
      ch2_x = (AW+3)'({che, 1'b0});
      cw4_x = (AW+3)'({cwe, 2'b00});
      nw_x  = (AW+1)'(atw_ff);
      nh_x  = (AW+1)'(ath_ff);
      t_x   = '0;

      if (rsp_ready) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               rw_in = req_rect_width;
               rh_in = req_rect_height;
               px_in = '1;
               py_in = '1;
               grown_in = 1'b0;
               if (req_type == REQ_CLEAR) begin
                  st_in    = ST_CLEARED;
                  cresp_in = 1'b1;
                  caddr_in = '0;
                  state_in = S_CLR;
               end else begin
                  state_in = S_WDIV_GO;
               end
            end
         end
         S_POW: begin
            if (pw_x < ch2_x || {pw_x[AW+1:0], 1'b0} < cw4_x) begin
               power_in = {power_ff[AW-2:0], 1'b0};
            end else begin
               atw_in   = {power_ff[AW-2:0], 1'b0};
               ath_in   = power_ff;
               gpath_in = 1'b0;
               state_in = S_COLS_GO;
            end
         end
         S_COLS_GO: begin
            div_start = 1'b1;
            div_dvd   = atw_ff;
            div_dvs   = cwe;
            state_in  = S_COLS_WT;
         end
         S_COLS_WT: begin
            if (!div_busy) begin
               cols_in  = sat_cnt(div_q);
               state_in = S_ROWS_GO;
            end
         end
         S_ROWS_GO: begin
            div_start = 1'b1;
            div_dvd   = ath_ff;
            div_dvs   = che;
            state_in  = S_ROWS_WT;
         end
         S_ROWS_WT: begin
            if (!div_busy) begin
               rows_in = sat_cnt(div_q);
               if (gpath_ff) begin
                  x_in     = '0;
                  y_in     = '0;
                  hset_in  = 1'b0;
                  state_in = S_SC_ROW;
               end else begin
                  cresp_in = 1'b0;
                  caddr_in = '0;
                  state_in = S_CLR;
               end
            end
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = caddr_ff;
            mem_wdata = '0;
            caddr_in  = caddr_ff + 1'b1;
            if (caddr_ff == ADW'(DEPTH - 1)) begin
               hc_in = '0;
               hr_in = '0;
               state_in = cresp_ff ? S_RESP : S_IDLE;
            end
         end
         S_WDIV_GO: begin
            div_start = 1'b1;
            div_dvd   = AW'(rw_ff) + AW'(cwe) - 1'b1;
            div_dvs   = cwe;
            state_in  = S_WDIV_WT;
         end
         S_WDIV_WT: begin
            if (!div_busy) begin
               cw_in = (rw_ff <= RECT_W'(cwe)) ? QW'(1) : div_q[QW-1:0];
               state_in = S_HDIV_GO;
            end
         end
         S_HDIV_GO: begin
            div_start = 1'b1;
            div_dvd   = AW'(rh_ff) + AW'(che) - 1'b1;
            div_dvs   = che;
            state_in  = S_HDIV_WT;
         end
         S_HDIV_WT: begin
            if (!div_busy) begin
               ch_in    = (rh_ff <= RECT_W'(che)) ? QW'(1) : div_q[QW-1:0];
               x_in     = XW'(hc_ff);
               y_in     = XW'(hr_ff);
               hset_in  = 1'b0;
               state_in = S_SC_ROW;
            end
         end
         S_SC_ROW: begin
            if (NW'(y_ff) + NW'(ch_ff) > NW'(rows_ff)) begin
               if (grown_ff) begin
                  st_in    = ST_NOFIT;
                  state_in = S_RESP;
               end else begin
                  if (atw_ff <= ath_ff) nw_x = {atw_ff, 1'b0};
                  else nh_x = {ath_ff, 1'b0};
                  if (nw_x > (AW+1)'(MAX_ATLAS_PX) || nh_x > (AW+1)'(MAX_ATLAS_PX)) begin
                     st_in    = ST_CLEARED;
                     cresp_in = 1'b1;
                     caddr_in = '0;
                     state_in = S_CLR;
                  end else begin
                     atw_in   = nw_x[AW-1:0];
                     ath_in   = nh_x[AW-1:0];
                     hc_in    = '0;
                     hr_in    = '0;
                     grown_in = 1'b1;
                     gpath_in = 1'b1;
                     state_in = S_COLS_GO;
                  end
               end
            end else if (NW'(x_ff) + NW'(cw_ff) > NW'(cols_ff)) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               i_in = '0;
               j_in = '0;
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            state_in = S_SC_CK;
         end
         S_SC_CK: begin
            if (mem_rdata != '0) begin
               t_x  = NW'(x_ff) + NW'(mem_rdata);
               x_in = t_x[XW-1:0];
               state_in = S_SC_ROW;
            end else begin
               if (i_ff == '0 && j_ff == '0 && !hset_ff) begin
                  hset_in = 1'b1;
                  hc_in   = x_ff[HW-1:0];
                  hr_in   = y_ff[HW-1:0];
               end
               state_in = S_SC_RD;
               if (QW'(i_ff) + 1'b1 == cw_ff) begin
                  i_in = '0;
                  if (QW'(j_ff) + 1'b1 == ch_ff) begin
                     j_in     = '0;
                     state_in = S_MARK;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         S_MARK: begin
            mem_we = 1'b1;
            if (QW'(i_ff) + 1'b1 == cw_ff) begin
               i_in = '0;
               if (QW'(j_ff) + 1'b1 == ch_ff) begin
                  j_in     = '0;
                  state_in = S_POS;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_POS: begin
            px_in    = pxm[RECT_W-1:0];
            py_in    = pym[RECT_W-1:0];
            st_in    = grown_ff ? ST_GROWN : ST_PLACED;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!ov_ff || rsp_ready) begin
               ov_in    = 1'b1;
               os_in    = st_ff;
               ox_in    = px_ff;
               oy_in    = py_ff;
               ow_in    = atw_ff[RECT_W-1:0];
               oh_in    = ath_ff[RECT_W-1:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_acc && (csr_index == CSR_CELL_W || csr_index == CSR_CELL_H)) begin
         if (csr_index == CSR_CELL_W) cellw_in = csr_data;
         else cellh_in = csr_data;
         power_in = AW'(MIN_POWER);
         state_in = S_POW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_POW;
         cellw_ff <= CELL_PX_W'(CELL_PX_RST);
         cellh_ff <= CELL_PX_W'(CELL_PX_RST);
         power_ff <= AW'(MIN_POWER);
         ov_ff    <= 1'b0;
         hset_ff  <= 1'b0;
         grown_ff <= 1'b0;
         gpath_ff <= 1'b0;
         cresp_ff <= 1'b0;
         hc_ff    <= '0;
         hr_ff    <= '0;
         caddr_ff <= '0;
      end else begin
         state_ff <= state_in;
         cellw_ff <= cellw_in;
         cellh_ff <= cellh_in;
         power_ff <= power_in;
         ov_ff    <= ov_in;
         hset_ff  <= hset_in;
         grown_ff <= grown_in;
         gpath_ff <= gpath_in;
         cresp_ff <= cresp_in;
         hc_ff    <= hc_in;
         hr_ff    <= hr_in;
         caddr_ff <= caddr_in;
      end
      atw_ff  <= atw_in;   ath_ff <= ath_in;
      cols_ff <= cols_in;  rows_ff <= rows_in;
      cw_ff   <= cw_in;    ch_ff <= ch_in;
      x_ff    <= x_in;     y_ff <= y_in;
      i_ff    <= i_in;     j_ff <= j_in;
      rw_ff   <= rw_in;    rh_ff <= rh_in;
      st_ff   <= st_in;    px_ff <= px_in;  py_ff <= py_in;
      os_ff   <= os_in;    ox_ff <= ox_in;  oy_ff <= oy_in;
      ow_ff   <= ow_in;    oh_ff <= oh_in;
   end

   gara_divider #(
      .DVW(AW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_q)
   );

   gara_grid_mem #(
      .DEPTH(DEPTH),
      .ADW  (ADW),
      .DW   (CNTW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_valid        = ov_ff;
   assign rsp_status       = os_ff;
   assign rsp_pos_x        = ox_ff;
   assign rsp_pos_y        = oy_ff;
   assign rsp_atlas_width  = ow_ff;
   assign rsp_atlas_height = oh_ff;

endmodule

`default_nettype wire
